### rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hash package
// Shared types and constants for the SHA-1 stream hash core and its round unit.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    localparam int unsigned WordBits  = 32;
    localparam int unsigned ChainBits = 5 * WordBits;
    localparam int unsigned BlockBits = 512;

    // Initial chaining value, word i in bits [32i+31:32i].
    localparam logic [ChainBits-1:0] CHAIN_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [WordBits-1:0] K_CH  = 32'h5A827999;
    localparam logic [WordBits-1:0] K_PAR = 32'h6ED9EBA1;
    localparam logic [WordBits-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WordBits-1:0] K_ODD = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;

    // Requests from the sequencer to the round unit.
    typedef struct packed {
        logic       push;       // shift one message byte into the block window
        logic [7:0] push_byte;
        logic       start;      // block complete: begin the 80 rounds
        logic       init;       // return the chaining words to their initial value
    } sha1sh_ctl_t;

    typedef struct packed {
        logic                 done;   // chaining words updated for the last block
        logic [ChainBits-1:0] chain;
    } sha1sh_stat_t;

    function automatic logic [WordBits-1:0] round_f(
        input logic [6:0]          rnd,
        input logic [WordBits-1:0] b,
        input logic [WordBits-1:0] c,
        input logic [WordBits-1:0] d
    );
        logic [WordBits-1:0] res;
        if (rnd < 7'd20) begin
            res = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            res = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            res = (b & c) | (b & d) | (c & d);
        end else begin
            res = b ^ c ^ d;
        end
        return res;
    endfunction

    function automatic logic [WordBits-1:0] round_k(input logic [6:0] rnd);
        logic [WordBits-1:0] res;
        if (rnd < 7'd20) begin
            res = K_CH;
        end else if (rnd < 7'd40) begin
            res = K_PAR;
        end else if (rnd < 7'd60) begin
            res = K_MAJ;
        end else begin
            res = K_ODD;
        end
        return res;
    endfunction

endpackage

### rtl/sha1sh_compress.sv
// ----------------------------------------------------------------------------
// SHA-1 round unit
// Holds the block window and the chaining words, and runs one compression
// round per cycle on a single shared round datapath.
// ----------------------------------------------------------------------------
module sha1sh_compress (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1sh_pkg::sha1sh_ctl_t  ctl,
    output sha1sh_pkg::sha1sh_stat_t stat
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_ADD
    } cstate_t;

    cstate_t     cstate_reg;
    logic        done_reg;
    logic [6:0]  rnd_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [sha1sh_pkg::ChainBits-1:0] chain_reg;
    // Sixteen schedule words, the oldest in the top 32 bits. Bytes enter at the
    // bottom, so after 64 bytes the first message word sits at the top.
    logic [sha1sh_pkg::BlockBits-1:0] win_reg;

    logic [31:0] w_cur;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] tmp;

    always_comb begin
        w_cur = win_reg[511:480];
        // Next schedule word from words t+13, t+8, t+2 and t of the window.
        w_mix = win_reg[95:64] ^ win_reg[255:224] ^ win_reg[447:416] ^ win_reg[511:480];
        w_new = {w_mix[30:0], w_mix[31]};
        tmp   = {a_reg[26:0], a_reg[31:27]}
              + sha1sh_pkg::round_f(rnd_reg, b_reg, c_reg, d_reg)
              + e_reg + sha1sh_pkg::round_k(rnd_reg) + w_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cstate_reg <= C_IDLE;
            done_reg   <= 1'b0;
            chain_reg  <= sha1sh_pkg::CHAIN_INIT;
        end else begin
            done_reg <= (cstate_reg == C_ADD);
            case (cstate_reg)
                C_IDLE: begin
                    if (ctl.init) begin
                        chain_reg <= sha1sh_pkg::CHAIN_INIT;
                    end
                    if (ctl.push) begin
                        win_reg <= {win_reg[503:0], ctl.push_byte};
                    end
                    if (ctl.start) begin
                        a_reg      <= chain_reg[31:0];
                        b_reg      <= chain_reg[63:32];
                        c_reg      <= chain_reg[95:64];
                        d_reg      <= chain_reg[127:96];
                        e_reg      <= chain_reg[159:128];
                        rnd_reg    <= 7'd0;
                        cstate_reg <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    a_reg   <= tmp;
                    b_reg   <= a_reg;
                    c_reg   <= {b_reg[1:0], b_reg[31:2]};
                    d_reg   <= c_reg;
                    e_reg   <= d_reg;
                    win_reg <= {win_reg[479:0], w_new};
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == sha1sh_pkg::ROUND_LAST) begin
                        cstate_reg <= C_ADD;
                    end
                end
                C_ADD: begin
                    chain_reg[31:0]    <= chain_reg[31:0]    + a_reg;
                    chain_reg[63:32]   <= chain_reg[63:32]   + b_reg;
                    chain_reg[95:64]   <= chain_reg[95:64]   + c_reg;
                    chain_reg[127:96]  <= chain_reg[127:96]  + d_reg;
                    chain_reg[159:128] <= chain_reg[159:128] + e_reg;
                    cstate_reg         <= C_IDLE;
                end
                default: begin
                    cstate_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.done  = done_reg;
    assign stat.chain = chain_reg;

endmodule

### rtl/sha1_stream_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hash core
// Absorbs a message one byte per request, pads it on the last request and
// returns the 160-bit digest.
//
//   Channel | Ports             | Contents
//   --------+-------------------+-------------------------------------------
//   input   | s_tvalid/s_tready | s_tdata: data_byte; s_tuser: byte_valid;
//           |                   | s_tlast: last
//   output  | m_tvalid/m_tready | m_tdata: digest_word_0 .. digest_word_4
//
// A byte request is taken straight away; the request that completes a 64-byte
// block then holds s_tready low while the round unit runs its 80 rounds,
// one per cycle, and adds into the chaining words.
// The last request is then followed by the padding bytes, a step at the length
// offset, the rounds and the addition for each final block (one or two) and the
// load of the digest.
// Reset is synchronous and active low; no clearing pass is needed.
// The digest waits in an output register, so new requests are taken while it
// is stalled; only a second digest waits for the first to be taken.
// ----------------------------------------------------------------------------
module sha1_stream_hash_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] byte_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // digest_word_0 [31:0] up to digest_word_4 [159:128]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_PADLEN,
        S_COMP,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    state_t         resume_reg, resume_next;
    state_t         after_push;
    logic [5:0]     fill_reg, fill_next;
    logic [60:0]    len_reg, len_next;
    logic [2:0]     lidx_reg, lidx_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [159:0]   m_tdata_reg, m_tdata_next;
    logic           push_en;
    logic [7:0]     push_val;
    logic [63:0]    bit_len;

    sha1sh_pkg::sha1sh_ctl_t  ctl;
    sha1sh_pkg::sha1sh_stat_t stat;

    sha1sh_compress u_compress (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat)
    );

    assign bit_len = {len_reg, 3'b000};

    always_comb begin
        resume_next   = resume_reg;
        fill_next     = fill_reg;
        len_next      = len_reg;
        lidx_next     = lidx_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        after_push    = state_reg;
        push_en       = 1'b0;
        push_val      = 8'h00;
        ctl           = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        push_en  = 1'b1;
                        push_val = s_tdata;
                        len_next = len_reg + 61'd1;
                    end
                    after_push = s_tlast ? S_PAD80 : S_IDLE;
                end
            end
            S_PAD80: begin
                push_en    = 1'b1;
                push_val   = sha1sh_pkg::PAD_BYTE;
                after_push = S_PADZ;
            end
            S_PADZ: begin
                if (fill_reg == sha1sh_pkg::LEN_OFFSET) begin
                    lidx_next  = 3'd0;
                    after_push = S_PADLEN;
                end else begin
                    push_en = 1'b1;
                end
            end
            S_PADLEN: begin
                push_en    = 1'b1;
                // Length goes out most significant byte first.
                push_val   = bit_len[{~lidx_reg, 3'b000} +: 8];
                lidx_next  = lidx_reg + 3'd1;
                after_push = (lidx_reg == 3'd7) ? S_EMIT : S_PADLEN;
            end
            S_COMP: begin
                if (stat.done) begin
                    after_push = resume_reg;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = stat.chain;
                    m_tvalid_next = 1'b1;
                    ctl.init      = 1'b1;
                    len_next      = 61'd0;
                    after_push    = S_IDLE;
                end
            end
            default: begin
                after_push = S_IDLE;
            end
        endcase

        state_next = after_push;
        if (push_en) begin
            ctl.push      = 1'b1;
            ctl.push_byte = push_val;
            fill_next     = fill_reg + 6'd1;
            // The byte that fills the block starts the rounds straight away.
            if (fill_reg == sha1sh_pkg::FILL_LAST) begin
                ctl.start   = 1'b1;
                resume_next = after_push;
                state_next  = S_COMP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            resume_reg   <= S_IDLE;
            fill_reg     <= 6'd0;
            len_reg      <= 61'd0;
            lidx_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            resume_reg   <= resume_next;
            fill_reg     <= fill_next;
            len_reg      <= len_next;
            lidx_reg     <= lidx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### rtl/sha1sh_checker.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hash port checker
// Watches the ports of the core over time and is bound to every instance.
// ----------------------------------------------------------------------------
module sha1sh_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         s_tlast,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);

    // A final request always leads to padding work, so the input must close.
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after a final request");

    // A request with no byte and no end changes nothing.
    a_idle_keeps_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && !s_tlast) |=> s_tready)
        else $error("input closed after an empty request");

    // A digest only appears at the end of the padding work.
    a_digest_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("digest appeared while the input was open");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled digest changed or was dropped");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("digest valid straight after reset");

endmodule

bind sha1_stream_hash_core sha1sh_checker u_sha1sh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hash core testbench
// Streams messages into the core one byte per request and checks every digest
// against a SHA-1 predictor kept in step with each accepted request. Covers
// empty messages, idle requests, padding that spills into a second block,
// random gaps on both channels and a long stall of the digest channel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned RandomItems  = 500;
    localparam int unsigned MinDigests   = 40;
    localparam int unsigned StallLimit   = 3000;
    localparam int unsigned DrainCycles  = 400;
    localparam int unsigned LongHold     = 400;
    localparam int unsigned MaxGap       = 6;

    localparam logic [159:0] SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };
    localparam logic [31:0] K_ROUNDS_00 = 32'h5A827999;
    localparam logic [31:0] K_ROUNDS_20 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUNDS_40 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUNDS_60 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_MARKER  = 8'h80;
    localparam int          LEN_POS     = 56;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tuser;   // [0] byte_valid
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // digest_word_0 [31:0] up to digest_word_4 [159:128]

    sha1_stream_hash_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state.
    logic [31:0]  hash_state [5];
    logic [7:0]   blk_bytes [64];
    int           blk_fill;
    logic [60:0]  msg_len;

    logic [159:0] pending_digests [$];
    int unsigned  digests_predicted;
    int unsigned  digests_seen;
    int unsigned  items_sent;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    bit           src_burst;
    bit           sink_burst;
    int unsigned  sink_hold;

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha1_restart();
        int i;
        for (i = 0; i < 5; i++) begin
            hash_state[i] = SHA1_IV[32*i +: 32];
        end
        blk_fill = 0;
        msg_len  = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        int t;
        for (t = 0; t < 16; t++) begin
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (t = 0; t < 80; t++) begin
            // The schedule is kept as a rolling window of sixteen words.
            if (t >= 16) begin
                w[t % 16] = rotl(w[(t - 3) % 16] ^ w[(t - 8) % 16] ^
                                 w[(t - 14) % 16] ^ w[t % 16], 1);
            end
            wt = w[t % 16];
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_ROUNDS_00;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_ROUNDS_20;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_ROUNDS_40;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUNDS_60;
            end
            sum = rotl(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void sha1_absorb(input logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 64) begin
            sha1_compress();
            blk_fill = 0;
        end
    endfunction

    // Applies one accepted request; queues a digest when the message ends.
    function automatic void sha1_take_request(input logic [7:0] data, input bit valid,
                                              input bit fin);
        logic [63:0]  bit_len;
        logic [159:0] digest;
        int i;
        if (valid) begin
            msg_len = msg_len + 61'd1;
            sha1_absorb(data);
        end
        if (fin) begin
            bit_len = {msg_len, 3'b000};
            sha1_absorb(PAD_MARKER);
            while (blk_fill != LEN_POS) begin
                sha1_absorb(8'h00);
            end
            for (i = 0; i < 8; i++) begin
                sha1_absorb(bit_len[63 - 8*i -: 8]);
            end
            for (i = 0; i < 5; i++) begin
                digest[32*i +: 32] = hash_state[i];
            end
            pending_digests.push_back(digest);
            digests_predicted++;
            sha1_restart();
        end
    endfunction

    task automatic send_request(input logic [7:0] data, input bit valid, input bit fin);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, MaxGap);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= valid;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sha1_take_request(data, valid, fin);
        if (valid || fin) begin
            items_sent++;
        end
    endtask

    // Sends a message of random bytes. The end is marked either on the final
    // byte or by a separate request that carries no byte.
    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        int i;
        bit fin;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            fin = end_on_byte && (i == len - 1);
            send_request(8'($urandom_range(0, 255)), 1'b1, fin);
        end
        if (!(end_on_byte && len > 0)) begin
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic test_directed_messages();
        // Empty message, then an idle request before another empty message.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hFF, 1'b0, 1'b0);
        send_request(8'h5A, 1'b0, 1'b1);
        // The classic three-byte message, ended on its final byte.
        send_request(8'h61, 1'b1, 1'b0);
        send_request(8'h62, 1'b1, 1'b0);
        send_request(8'h63, 1'b1, 1'b1);
        // Extreme byte values, an idle request inside, a byte-free terminator.
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hFF, 1'b1, 1'b0);
        send_request(8'hA5, 1'b0, 1'b0);
        send_request(8'hFF, 1'b0, 1'b1);
        // Single-byte messages at both extremes and at 0x80.
        send_request(8'hFF, 1'b1, 1'b1);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'h80, 1'b1, 1'b1);
    endtask

    task automatic test_padding_boundaries();
        int lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int i;
        for (i = 0; i < 10; i++) begin
            send_message(lens[i], i % 2 == 0, 0);
        end
    endtask

    // The digest channel stalls for a long stretch while short messages keep
    // coming, so the output register fills and the core refuses requests.
    task automatic test_output_backpressure();
        int i;
        src_burst = 1'b1;
        sink_hold = LongHold;
        for (i = 0; i < 8; i++) begin
            send_message(int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)), 0);
        end
        src_burst = 1'b0;
    endtask

    task automatic test_random_messages();
        int edge_lens [9] = '{55, 56, 63, 64, 119, 120, 127, 128, 200};
        int unsigned first_item;
        int len;
        int pick;
        first_item = items_sent;
        while (items_sent - first_item < RandomItems || digests_predicted < MinDigests) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = $urandom_range(0, 12);
            end else if (pick < 85) begin
                len = $urandom_range(13, 70);
            end else begin
                len = edge_lens[$urandom_range(0, 8)];
            end
            src_burst  = ($urandom_range(0, 4) == 0);
            sink_burst = ($urandom_range(0, 4) == 0);
            send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 1) ? 10 : 0);
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;
    endtask

    // Digest receiver: random gaps per digest, plus the long hold on request.
    initial begin : digest_sink
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = sink_burst ? 0 : $urandom_range(0, MaxGap);
            repeat (gap) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end
            while (sink_hold > 0) begin
                m_tready <= 1'b0;
                sink_hold--;
                @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) begin
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : digest_check
        logic [159:0] want;
        int i;
        if (aresetn && m_tvalid && m_tready) begin
            digests_seen++;
            if (pending_digests.size() == 0) begin
                report_error($sformatf("digest %h arrived with none expected", m_tdata));
            end else begin
                want = pending_digests.pop_front();
                for (i = 0; i < 5; i++) begin
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                        report_error($sformatf("digest %0d word %0d: got %h, expected %h",
                                               digests_seen, i, m_tdata[32*i +: 32],
                                               want[32*i +: 32]));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : stall_watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("sha1_stream_hash_core verification failed");
            $finish;
        end
    end

    initial begin
        aresetn           = 1'b0;
        s_tvalid          = 1'b0;
        s_tdata           = 8'h00;
        s_tuser           = 1'b0;
        s_tlast           = 1'b0;
        src_burst         = 1'b0;
        sink_burst        = 1'b0;
        sink_hold         = 0;
        digests_predicted = 0;
        digests_seen      = 0;
        items_sent        = 0;
        error_count       = 0;
        quiet_cycles      = 0;
        sha1_restart();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_messages();
        test_padding_boundaries();
        test_output_backpressure();
        test_random_messages();

        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0) begin
            $display("sha1_stream_hash_core verification clean");
        end else begin
            $display("sha1_stream_hash_core verification failed");
        end
        $finish;
    end

endmodule
